### sv/pfs_pkg.sv
// shared types and constants for the streaming prefix function block
`timescale 1ns / 1ps

package pfs_pkg;

    localparam int DEFAULT_MAX_LEN = 4096;
    localparam int SYMBOL_W        = 8;
    localparam int BORDER_W        = 12;
    localparam int IN_TDATA_W      = 8;
    localparam int OUT_TDATA_W     = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT_B,
        ST_CMP,
        ST_FINISH
    } pfs_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic b_rd_pos;
        logic b_rd_len;
        logic len_from_b;
        logic len_inc;
        logic wr_en;
        logic load_out;
    } pfs_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic in_first;
        logic in_full;
        logic match;
        logic len_zero;
        logic ovf;
    } pfs_status_t;

endpackage

### sv/pfs_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module pfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/pfs_ctrl.sv
// controller state machine for the prefix function block
`timescale 1ns / 1ps

module pfs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  pfs_pkg::pfs_status_t status,
    output pfs_pkg::pfs_cmd_t    cmd
);

    pfs_pkg::pfs_state_t state_reg;
    pfs_pkg::pfs_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                accept;
    logic                out_free;

    assign accept   = s_tvalid && (state_reg == pfs_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (status.in_full || status.in_first)
                    begin
                        state_next = pfs_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = pfs_pkg::ST_WAIT_B;
                    end
                end
            end
            pfs_pkg::ST_WAIT_B:
            begin
                state_next = pfs_pkg::ST_CMP;
            end
            pfs_pkg::ST_CMP:
            begin
                if (!status.match && !status.len_zero)
                begin
                    state_next = pfs_pkg::ST_WAIT_B;
                end
                else
                begin
                    state_next = pfs_pkg::ST_FINISH;
                end
            end
            pfs_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = pfs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.accept     = accept;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            pfs_pkg::ST_IDLE:
            begin
                cmd.b_rd_pos = accept && !status.in_first && !status.in_full;
            end
            pfs_pkg::ST_WAIT_B:
            begin
                cmd.len_from_b = 1'b1;
            end
            pfs_pkg::ST_CMP:
            begin
                cmd.len_inc  = status.match;
                cmd.b_rd_len = !status.match && !status.len_zero;
            end
            pfs_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.wr_en      = !status.ovf;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign s_tready = (state_reg == pfs_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

### sv/pfs_datapath.sv
// datapath: symbol and border stores, candidate length, output register
`timescale 1ns / 1ps

module pfs_datapath #(
    parameter int MAX_LEN = pfs_pkg::DEFAULT_MAX_LEN
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pfs_pkg::SYMBOL_W-1:0]  in_symbol,
    input  logic                          in_start,
    input  pfs_pkg::pfs_cmd_t             cmd,
    output pfs_pkg::pfs_status_t          status,
    output logic [pfs_pkg::BORDER_W-1:0]  out_border,
    output logic                          out_overflow
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int PW = $clog2(MAX_LEN + 1);

    logic [PW-1:0]                position_reg;
    logic [PW-1:0]                position_next;
    logic [PW-1:0]                pos_reg;
    logic [PW-1:0]                pos_m1;
    logic [AW-1:0]                len_reg;
    logic [pfs_pkg::SYMBOL_W-1:0] sym_reg;
    logic                         ovf_reg;
    logic [pfs_pkg::BORDER_W-1:0] border_out_reg;
    logic                         ovf_out_reg;

    logic [AW-1:0]                b_raddr;
    logic [AW-1:0]                b_rdata;
    logic [pfs_pkg::SYMBOL_W-1:0] s_rdata;
    logic                         in_full;
    logic                         in_first;

    assign in_first = in_start || (position_reg == '0);
    assign in_full  = !in_start && (position_reg >= PW'(MAX_LEN));
    assign pos_m1   = position_reg - PW'(1);
    assign b_raddr  = cmd.b_rd_len ? (len_reg - AW'(1)) : pos_m1[AW-1:0];

    pfs_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_LEN)
    ) u_border_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (pos_reg[AW-1:0]),
        .wdata (len_reg),
        .re    (cmd.b_rd_pos || cmd.b_rd_len),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // the fetched link addresses the symbol after the candidate border
    pfs_ram #(
        .WIDTH (pfs_pkg::SYMBOL_W),
        .DEPTH (MAX_LEN)
    ) u_symbol_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (pos_reg[AW-1:0]),
        .wdata (sym_reg),
        .re    (cmd.len_from_b),
        .raddr (b_rdata),
        .rdata (s_rdata)
    );

    always_comb
    begin
        position_next = position_reg;
        if (cmd.wr_en)
        begin
            position_next = pos_reg + PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
        end
        else
        begin
            position_reg <= position_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sym_reg <= in_symbol;
            pos_reg <= in_start ? '0 : position_reg;
            ovf_reg <= in_full;
            len_reg <= '0;
        end
        else if (cmd.len_from_b)
        begin
            len_reg <= b_rdata;
        end
        else if (cmd.len_inc)
        begin
            len_reg <= len_reg + AW'(1);
        end
        if (cmd.load_out)
        begin
            border_out_reg <= pfs_pkg::BORDER_W'(len_reg);
            ovf_out_reg    <= ovf_reg;
        end
    end

    assign status.in_first = in_first;
    assign status.in_full  = in_full;
    assign status.match    = (sym_reg == s_rdata);
    assign status.len_zero = (len_reg == '0);
    assign status.ovf      = ovf_reg;

    assign out_border   = border_out_reg;
    assign out_overflow = ovf_out_reg;

endmodule

### sv/prefix_function_stream.sv
// top level of the streaming prefix function block
`timescale 1ns / 1ps

// Takes a string one byte per word and returns, for each byte, the length of the
// longest proper prefix of the string so far that is also its suffix. A word with
// start_of_string set begins a new string and gives 0; the first word after reset
// starts one too. Up to MAX_LEN bytes are kept; further bytes of the same string are
// dropped and answered with overflow set and length 0. One word is in flight at a
// time. A first byte or a dropped byte goes from ST_IDLE straight to ST_FINISH; any
// other byte passes ST_WAIT_B and ST_CMP once, and again for each of the k failure
// links followed back, each link costing one border ram read and one symbol ram read.
// Averaged over a string, k stays below one per byte. A result waiting on m_tready
// holds the block in ST_FINISH.
module prefix_function_stream #(
    parameter int MAX_LEN = pfs_pkg::DEFAULT_MAX_LEN
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pfs_pkg::IN_TDATA_W-1:0]  s_tdata,  // [7:0] symbol
    input  logic                            s_tuser,  // [0] start_of_string
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pfs_pkg::OUT_TDATA_W-1:0] m_tdata,  // [11:0] border_length, [15:12] zero
    output logic                            m_tuser   // [0] overflow
);

    pfs_pkg::pfs_cmd_t            cmd;
    pfs_pkg::pfs_status_t         status;
    logic [pfs_pkg::BORDER_W-1:0] border;

    pfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pfs_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_symbol    (s_tdata[pfs_pkg::SYMBOL_W-1:0]),
        .in_start     (s_tuser),
        .cmd          (cmd),
        .status       (status),
        .out_border   (border),
        .out_overflow (m_tuser)
    );

    assign m_tdata = {{(pfs_pkg::OUT_TDATA_W - pfs_pkg::BORDER_W){1'b0}}, border};

    // one word in flight
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word accepted while one is in flight");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("result register overwritten before it was taken");

    a_write_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> cmd.load_out)
        else $error("stores written without issuing a result");

    a_overflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata == '0))
        else $error("dropped byte returned a nonzero length");

endmodule
